[rtl/smbmd_pkg.sv]
// Shared types, offsets and codes for the SMBIOS memory device parser.
// No dependencies; used by the decode module and the top level.
package smbmd_pkg;

	// Parse phases.
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_STRINGS = 2'd1;
	localparam logic [1:0] PH_HALT    = 2'd2;

	// Structure type of a memory device.
	localparam logic [7:0] TYPE_MEMORY_DEVICE = 8'd17;

	// Smallest legal header length.
	localparam logic [7:0] MIN_HDR_LEN = 8'd4;

	// Byte offsets inside the formatted area.
	localparam logic [7:0] OFS_SIZE_LO   = 8'h0C;
	localparam logic [7:0] OFS_SIZE_HI   = 8'h0D;
	localparam logic [7:0] OFS_LOCATOR   = 8'h10;
	localparam logic [7:0] OFS_BANK      = 8'h11;
	localparam logic [7:0] OFS_MEM_TYPE  = 8'h12;
	localparam logic [7:0] OFS_SPEED_LO  = 8'h15;
	localparam logic [7:0] OFS_SPEED_HI  = 8'h16;
	localparam logic [7:0] OFS_EXT_B0    = 8'h1C;
	localparam logic [7:0] OFS_EXT_B1    = 8'h1D;
	localparam logic [7:0] OFS_EXT_B2    = 8'h1E;
	localparam logic [7:0] OFS_EXT_B3    = 8'h1F;
	localparam logic [7:0] OFS_CSPEED_LO = 8'h20;
	localparam logic [7:0] OFS_CSPEED_HI = 8'h21;
	localparam logic [7:0] OFS_VOLT_LO   = 8'h26;
	localparam logic [7:0] OFS_VOLT_HI   = 8'h27;

	// Special size word values.
	localparam logic [15:0] SIZE_NONE     = 16'h0000;
	localparam logic [15:0] SIZE_UNKNOWN  = 16'hFFFF;
	localparam logic [15:0] SIZE_EXTENDED = 16'h7FFF;

	// Raw memory type codes.
	localparam logic [7:0] MT_DDR  = 8'h12;
	localparam logic [7:0] MT_DDR2 = 8'h13;
	localparam logic [7:0] MT_DDR3 = 8'h18;
	localparam logic [7:0] MT_DDR4 = 8'h1A;
	localparam logic [7:0] MT_DDR5 = 8'h22;

	// Reported memory kinds.
	localparam logic [2:0] KIND_UNKNOWN = 3'd0;
	localparam logic [2:0] KIND_DDR     = 3'd1;
	localparam logic [2:0] KIND_DDR2    = 3'd2;
	localparam logic [2:0] KIND_DDR3    = 3'd3;
	localparam logic [2:0] KIND_DDR4    = 3'd4;
	localparam logic [2:0] KIND_DDR5    = 3'd5;

	// Header and field values captured from one structure.
	typedef struct packed {
		logic [7:0]  struct_kind;
		logic [7:0]  struct_length;
		logic [15:0] size_word;
		logic [31:0] extended_size;
		logic [7:0]  locator_index;
		logic [7:0]  bank_index;
		logic [7:0]  kind_code;
		logic [15:0] speed_word;
		logic [15:0] set_speed_word;
		logic [15:0] voltage_word;
	} fields_t;

	// One decoded memory device record.
	typedef struct packed {
		logic [30:0] size_mib;
		logic [15:0] max_speed_mts;
		logic [15:0] configured_speed_mts;
		logic [15:0] voltage_mv;
		logic [2:0]  memory_kind;
		logic [7:0]  locator_string;
		logic [7:0]  bank_string;
	} record_t;

	// Map a raw memory type code to the reported kind.
	function automatic logic [2:0] kind_of(input logic [7:0] code);
		logic [2:0] k;
		unique case (code)
			MT_DDR:  k = KIND_DDR;
			MT_DDR2: k = KIND_DDR2;
			MT_DDR3: k = KIND_DDR3;
			MT_DDR4: k = KIND_DDR4;
			MT_DDR5: k = KIND_DDR5;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

[rtl/smbios_memory_device_parser_core.sv]
// Throughput: one table byte per cycle; input ready drops only while a byte that
// completes a record meets an earlier record still waiting at the output.
// A record appears on the output in the cycle after the transfer of the byte
// that closes its structure (second zero of the string set, or the table end).
// Reset: arst_n clears the parse phase, byte position, zero flag and output valid.
// Depends on smbmd_pkg and smbmd_record_decode.
module smbios_memory_device_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  table_byte,
	input  logic        table_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] size_mib,
	output logic [15:0] max_speed_mts,
	output logic [15:0] configured_speed_mts,
	output logic [15:0] voltage_mv,
	output logic [2:0]  memory_kind,
	output logic [7:0]  locator_string,
	output logic [7:0]  bank_string
);

	logic [1:0] phase_q, phase_n;
	logic [7:0] pos_q, pos_n;
	logic       lz_q, lz_n;
	smbmd_pkg::fields_t fld_q, fld_n;
	logic       finish;
	logic       done;
	logic       dec_valid;
	smbmd_pkg::record_t dec_rec;
	smbmd_pkg::record_t rec_q;
	logic       out_valid_q;
	logic       emit;
	logic       accept;

	// Next parse state and captured fields for the byte at the input.
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		lz_n    = lz_q;
		fld_n   = fld_q;
		done    = 1'b0;
		finish  = 1'b0;
		unique case (phase_q)
			smbmd_pkg::PH_HEADER: begin
				if (pos_q == 8'd0) begin
					fld_n = '0;
					fld_n.struct_kind = table_byte;
				end else if (pos_q == 8'd1) begin
					fld_n.struct_length = table_byte;
					if (table_byte < smbmd_pkg::MIN_HDR_LEN) begin
						phase_n = smbmd_pkg::PH_HALT;
					end
				end else begin
					case (pos_q)
						smbmd_pkg::OFS_SIZE_LO:   fld_n.size_word[7:0]       = table_byte;
						smbmd_pkg::OFS_SIZE_HI:   fld_n.size_word[15:8]      = table_byte;
						smbmd_pkg::OFS_LOCATOR:   fld_n.locator_index        = table_byte;
						smbmd_pkg::OFS_BANK:      fld_n.bank_index           = table_byte;
						smbmd_pkg::OFS_MEM_TYPE:  fld_n.kind_code            = table_byte;
						smbmd_pkg::OFS_SPEED_LO:  fld_n.speed_word[7:0]      = table_byte;
						smbmd_pkg::OFS_SPEED_HI:  fld_n.speed_word[15:8]     = table_byte;
						smbmd_pkg::OFS_EXT_B0:    fld_n.extended_size[7:0]   = table_byte;
						smbmd_pkg::OFS_EXT_B1:    fld_n.extended_size[15:8]  = table_byte;
						smbmd_pkg::OFS_EXT_B2:    fld_n.extended_size[23:16] = table_byte;
						smbmd_pkg::OFS_EXT_B3:    fld_n.extended_size[31:24] = table_byte;
						smbmd_pkg::OFS_CSPEED_LO: fld_n.set_speed_word[7:0]  = table_byte;
						smbmd_pkg::OFS_CSPEED_HI: fld_n.set_speed_word[15:8] = table_byte;
						smbmd_pkg::OFS_VOLT_LO:   fld_n.voltage_word[7:0]    = table_byte;
						smbmd_pkg::OFS_VOLT_HI:   fld_n.voltage_word[15:8]   = table_byte;
						default: ;
					endcase
				end
				if (phase_n == smbmd_pkg::PH_HEADER) begin
					pos_n = pos_q + 8'd1;
					if (pos_n >= 8'd2 && pos_n >= fld_n.struct_length) begin
						phase_n = smbmd_pkg::PH_STRINGS;
						lz_n    = 1'b0;
					end
				end
			end
			smbmd_pkg::PH_STRINGS: begin
				// Two zero bytes in a row close the string set.
				if (table_byte == 8'd0 && lz_q) begin
					finish  = 1'b1;
					done    = 1'b1;
					phase_n = smbmd_pkg::PH_HEADER;
					pos_n   = 8'd0;
					lz_n    = 1'b0;
				end else begin
					lz_n = (table_byte == 8'd0);
				end
			end
			default: ;
		endcase
		// The table end flushes a structure of at least four bytes.
		if (table_end) begin
			if (!done && ((phase_n == smbmd_pkg::PH_HEADER && pos_n >= 8'd4) ||
			              phase_n == smbmd_pkg::PH_STRINGS)) begin
				finish = 1'b1;
			end
			phase_n = smbmd_pkg::PH_HEADER;
			pos_n   = 8'd0;
			lz_n    = 1'b0;
		end
	end

	smbmd_record_decode u_decode (
		.fld   (fld_n),
		.valid (dec_valid),
		.rec   (dec_rec)
	);

	// A byte that yields a record waits only while the output is full and stalled.
	assign emit     = finish && dec_valid;
	assign in_ready = !out_valid_q || out_ready || !emit;
	assign accept   = in_valid && in_ready;

	// Parse control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= smbmd_pkg::PH_HEADER;
			pos_q   <= 8'd0;
			lz_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			lz_q    <= lz_n;
		end
	end

	// Captured fields; the type byte of each structure reloads them.
	always_ff @(posedge clk) begin
		if (accept) begin
			fld_q <= fld_n;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rec_q <= dec_rec;
		end
	end

	assign out_valid            = out_valid_q;
	assign size_mib             = rec_q.size_mib;
	assign max_speed_mts        = rec_q.max_speed_mts;
	assign configured_speed_mts = rec_q.configured_speed_mts;
	assign voltage_mv           = rec_q.voltage_mv;
	assign memory_kind          = rec_q.memory_kind;
	assign locator_string       = rec_q.locator_string;
	assign bank_string          = rec_q.bank_string;

endmodule

[rtl/smbmd_record_decode.sv]
// Decodes the captured fields of one structure into a memory device record.
// Depends on smbmd_pkg for the field and record types.
module smbmd_record_decode (
	input  smbmd_pkg::fields_t fld,
	output logic               valid,
	output smbmd_pkg::record_t rec
);

	logic [7:0]  len;
	logic [15:0] sw;
	logic [31:0] ext;
	logic [30:0] size;
	logic [15:0] spd;
	logic [15:0] cspd;

	assign len = fld.struct_length;

	// Fields that lie beyond the formatted area read as zero.
	assign sw   = (len >= 8'h0E) ? fld.size_word : 16'd0;
	assign ext  = (len >= 8'h20) ? fld.extended_size : 32'd0;
	assign spd  = (len >= 8'h17) ? fld.speed_word : 16'd0;
	assign cspd = (len >= 8'h22) ? fld.set_speed_word : 16'd0;

	// Size decode: none, unknown, extended form, KiB form, or plain MiB.
	always_comb begin
		if (sw == smbmd_pkg::SIZE_NONE || sw == smbmd_pkg::SIZE_UNKNOWN) begin
			size = 31'd0;
		end else if (sw == smbmd_pkg::SIZE_EXTENDED) begin
			size = ext[30:0];
		end else if (sw[15]) begin
			// KiB count divided by 1024.
			size = {26'd0, sw[14:10]};
		end else begin
			size = {15'd0, sw};
		end
	end

	assign valid = (fld.struct_kind == smbmd_pkg::TYPE_MEMORY_DEVICE) && (size != 31'd0);

	// Assemble the record; configured speed falls back to the rated speed.
	always_comb begin
		rec.size_mib             = size;
		rec.max_speed_mts        = spd;
		rec.configured_speed_mts = (cspd == 16'd0) ? spd : cspd;
		rec.voltage_mv           = (len >= 8'h28) ? fld.voltage_word : 16'd0;
		rec.memory_kind          = smbmd_pkg::kind_of((len > 8'h12) ? fld.kind_code : 8'd0);
		rec.locator_string       = (len > 8'h10) ? fld.locator_index : 8'd0;
		rec.bank_string          = (len > 8'h11) ? fld.bank_index : 8'd0;
	end

endmodule

[rtl/smbmd_checker.sv]
// Port-level checks for the SMBIOS memory device parser, bound to the top level.
// Depends only on the top level's ports.
module smbmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  table_byte,
	input logic        table_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] size_mib,
	input logic [15:0] max_speed_mts,
	input logic [15:0] configured_speed_mts,
	input logic [15:0] voltage_mv,
	input logic [2:0]  memory_kind,
	input logic [7:0]  locator_string,
	input logic [7:0]  bank_string
);

	// A stalled record holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(size_mib) &&
		$stable(locator_string) && $stable(bank_string))
		else $error("stalled record changed");

	// Every record carries a nonzero size.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> size_mib != 31'd0)
		else $error("record with zero size");

	// Configured speed is zero only when the rated speed is zero too.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> configured_speed_mts != 16'd0 || max_speed_mts == 16'd0)
		else $error("configured speed fallback missed");

	// A nonzero byte that is not the table end never closes a structure.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && table_byte != 8'd0 && !table_end &&
		!(out_valid && !out_ready) |=> !out_valid)
		else $error("record from a byte that cannot close a structure");

	// Memory kind stays within its defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> memory_kind <= 3'd5)
		else $error("memory kind out of range");

endmodule

bind smbios_memory_device_parser_core smbmd_checker u_smbmd_checker (.*);

[tb/tb_smbios_memory_device_parser_core.sv]
// Self-checking testbench for smbios_memory_device_parser_core: streams SMBIOS tables
// byte by byte and checks every memory device record against an in-bench predictor.
// Depends on smbmd_pkg and the parser core RTL.
module tb_smbios_memory_device_parser_core;

	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES      = 8;
	localparam int unsigned RUN_LIMIT        = 3_000_000;
	localparam int unsigned RANDOM_BYTES     = 850;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  table_byte = 8'h00;
	logic        table_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] size_mib;
	logic [15:0] max_speed_mts;
	logic [15:0] configured_speed_mts;
	logic [15:0] voltage_mv;
	logic [2:0]  memory_kind;
	logic [7:0]  locator_string;
	logic [7:0]  bank_string;

	smbios_memory_device_parser_core dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.table_byte           (table_byte),
		.table_end            (table_end),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.size_mib             (size_mib),
		.max_speed_mts        (max_speed_mts),
		.configured_speed_mts (configured_speed_mts),
		.voltage_mv           (voltage_mv),
		.memory_kind          (memory_kind),
		.locator_string       (locator_string),
		.bank_string          (bank_string)
	);

	// Clock with a period of 10 time units.
	always #5 clk = ~clk;

	// Idling controls shared by the sender and the receiver.
	bit sender_gaps     = 1'b1;
	bit receiver_stalls = 1'b1;
	bit long_hold       = 1'b0;

	int unsigned errors       = 0;
	int unsigned bytes_parsed = 0;

	// Records the predictor expects, oldest first.
	smbmd_pkg::record_t expected_records[$];

	// Bytes of the table that is about to be streamed.
	logic [7:0] table_bytes[$];

	// Mirror of the parser state, kept by the predictor.
	logic [1:0]  parse_state = smbmd_pkg::PH_HEADER;
	logic [7:0]  position    = 8'h00;
	logic [7:0]  header_type = 8'h00;
	logic [7:0]  header_len  = 8'h00;
	logic        prev_zero   = 1'b0;
	logic [15:0] raw_size    = 16'h0000;
	logic [31:0] raw_ext     = 32'h0;
	logic [7:0]  raw_loc     = 8'h00;
	logic [7:0]  raw_bank    = 8'h00;
	logic [7:0]  raw_type    = 8'h00;
	logic [15:0] raw_speed   = 16'h0000;
	logic [15:0] raw_cspeed  = 16'h0000;
	logic [15:0] raw_volt    = 16'h0000;

	function automatic void report_error(input string what);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t: %s", $time, what);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
	endfunction

	// Add one byte at the tail of the pending table.
	function automatic void append_byte(input logic [7:0] b);
		table_bytes.insert(table_bytes.size(), b);
	endfunction

	// Decode the structure that just ended and queue its record when it has one.
	function automatic void close_structure();
		smbmd_pkg::record_t rec;
		logic [15:0] word;
		logic [31:0] ext;
		logic [31:0] mib;
		logic [7:0]  code;
		if (header_type != smbmd_pkg::TYPE_MEMORY_DEVICE)
			return;
		word = (header_len > smbmd_pkg::OFS_SIZE_HI) ? raw_size : smbmd_pkg::SIZE_NONE;
		ext  = (header_len > smbmd_pkg::OFS_EXT_B3) ? raw_ext : 32'h0;
		if (word == smbmd_pkg::SIZE_NONE || word == smbmd_pkg::SIZE_UNKNOWN)
			mib = 32'h0;
		else if (word == smbmd_pkg::SIZE_EXTENDED)
			mib = {1'b0, ext[30:0]};
		else if (word[15])
			mib = {17'h0, word[14:0]} >> 10;
		else
			mib = {16'h0, word};
		if (mib == 32'h0)
			return;
		rec.size_mib             = mib[30:0];
		rec.max_speed_mts        = (header_len > smbmd_pkg::OFS_SPEED_HI) ? raw_speed : 16'h0;
		rec.configured_speed_mts = (header_len > smbmd_pkg::OFS_CSPEED_HI) ?
			raw_cspeed : 16'h0;
		if (rec.configured_speed_mts == 16'h0)
			rec.configured_speed_mts = rec.max_speed_mts;
		rec.voltage_mv     = (header_len > smbmd_pkg::OFS_VOLT_HI) ? raw_volt : 16'h0;
		rec.locator_string = (header_len > smbmd_pkg::OFS_LOCATOR) ? raw_loc : 8'h00;
		rec.bank_string    = (header_len > smbmd_pkg::OFS_BANK) ? raw_bank : 8'h00;
		code = (header_len > smbmd_pkg::OFS_MEM_TYPE) ? raw_type : 8'h00;
		case (code)
			smbmd_pkg::MT_DDR:  rec.memory_kind = smbmd_pkg::KIND_DDR;
			smbmd_pkg::MT_DDR2: rec.memory_kind = smbmd_pkg::KIND_DDR2;
			smbmd_pkg::MT_DDR3: rec.memory_kind = smbmd_pkg::KIND_DDR3;
			smbmd_pkg::MT_DDR4: rec.memory_kind = smbmd_pkg::KIND_DDR4;
			smbmd_pkg::MT_DDR5: rec.memory_kind = smbmd_pkg::KIND_DDR5;
			default:            rec.memory_kind = smbmd_pkg::KIND_UNKNOWN;
		endcase
		expected_records.insert(expected_records.size(), rec);
	endfunction

	// Advance the mirrored parser by one transferred table byte.
	function automatic void predict_table_byte(input logic [7:0] b, input logic last);
		logic closed;
		closed = 1'b0;
		if (parse_state != smbmd_pkg::PH_HALT)
			bytes_parsed++;
		if (parse_state == smbmd_pkg::PH_HEADER) begin
			if (position == 8'd0) begin
				raw_size    = 16'h0;
				raw_ext     = 32'h0;
				raw_loc     = 8'h00;
				raw_bank    = 8'h00;
				raw_type    = 8'h00;
				raw_speed   = 16'h0;
				raw_cspeed  = 16'h0;
				raw_volt    = 16'h0;
				header_type = b;
				header_len  = 8'h00;
			end else if (position == 8'd1) begin
				header_len = b;
				if (b < smbmd_pkg::MIN_HDR_LEN)
					parse_state = smbmd_pkg::PH_HALT;
			end else begin
				case (position)
					smbmd_pkg::OFS_SIZE_LO:   raw_size[7:0]    = b;
					smbmd_pkg::OFS_SIZE_HI:   raw_size[15:8]   = b;
					smbmd_pkg::OFS_LOCATOR:   raw_loc          = b;
					smbmd_pkg::OFS_BANK:      raw_bank         = b;
					smbmd_pkg::OFS_MEM_TYPE:  raw_type         = b;
					smbmd_pkg::OFS_SPEED_LO:  raw_speed[7:0]   = b;
					smbmd_pkg::OFS_SPEED_HI:  raw_speed[15:8]  = b;
					smbmd_pkg::OFS_EXT_B0:    raw_ext[7:0]     = b;
					smbmd_pkg::OFS_EXT_B1:    raw_ext[15:8]    = b;
					smbmd_pkg::OFS_EXT_B2:    raw_ext[23:16]   = b;
					smbmd_pkg::OFS_EXT_B3:    raw_ext[31:24]   = b;
					smbmd_pkg::OFS_CSPEED_LO: raw_cspeed[7:0]  = b;
					smbmd_pkg::OFS_CSPEED_HI: raw_cspeed[15:8] = b;
					smbmd_pkg::OFS_VOLT_LO:   raw_volt[7:0]    = b;
					smbmd_pkg::OFS_VOLT_HI:   raw_volt[15:8]   = b;
					default: ;
				endcase
			end
			if (parse_state == smbmd_pkg::PH_HEADER) begin
				position = position + 8'd1;
				if (position >= 8'd2 && position >= header_len) begin
					parse_state = smbmd_pkg::PH_STRINGS;
					prev_zero   = 1'b0;
				end
			end
		end else if (parse_state == smbmd_pkg::PH_STRINGS) begin
			if (b == 8'h00 && prev_zero) begin
				close_structure();
				closed      = 1'b1;
				parse_state = smbmd_pkg::PH_HEADER;
				position    = 8'd0;
				prev_zero   = 1'b0;
			end else begin
				prev_zero = (b == 8'h00);
			end
		end
		// The last byte of a table flushes a structure that was cut off.
		if (last) begin
			if (!closed && ((parse_state == smbmd_pkg::PH_HEADER && position >= 8'd4) ||
					parse_state == smbmd_pkg::PH_STRINGS))
				close_structure();
			parse_state = smbmd_pkg::PH_HEADER;
			position    = 8'd0;
			prev_zero   = 1'b0;
		end
	endfunction

	// Append a structure header and formatted area with the given field values.
	function automatic void push_memory_device(input logic [7:0] kind, input logic [7:0] len,
			input logic [15:0] word, input logic [31:0] ext, input logic [7:0] code,
			input logic [7:0] loc, input logic [7:0] bank, input logic [15:0] speed,
			input logic [15:0] cspeed, input logic [15:0] volt, input bit filler);
		logic [7:0] area [0:255];
		for (int i = 0; i < 256; i++)
			area[i] = filler ? 8'($urandom_range(0, 255)) : 8'h00;
		area[0]                        = kind;
		area[1]                        = len;
		area[smbmd_pkg::OFS_SIZE_LO]   = word[7:0];
		area[smbmd_pkg::OFS_SIZE_HI]   = word[15:8];
		area[smbmd_pkg::OFS_LOCATOR]   = loc;
		area[smbmd_pkg::OFS_BANK]      = bank;
		area[smbmd_pkg::OFS_MEM_TYPE]  = code;
		area[smbmd_pkg::OFS_SPEED_LO]  = speed[7:0];
		area[smbmd_pkg::OFS_SPEED_HI]  = speed[15:8];
		area[smbmd_pkg::OFS_EXT_B0]    = ext[7:0];
		area[smbmd_pkg::OFS_EXT_B1]    = ext[15:8];
		area[smbmd_pkg::OFS_EXT_B2]    = ext[23:16];
		area[smbmd_pkg::OFS_EXT_B3]    = ext[31:24];
		area[smbmd_pkg::OFS_CSPEED_LO] = cspeed[7:0];
		area[smbmd_pkg::OFS_CSPEED_HI] = cspeed[15:8];
		area[smbmd_pkg::OFS_VOLT_LO]   = volt[7:0];
		area[smbmd_pkg::OFS_VOLT_HI]   = volt[15:8];
		for (int i = 0; i < 256; i++)
			if (i < 2 || i < len)
				append_byte(area[i]);
	endfunction

	// Append a string set of n strings, closed by the double zero.
	function automatic void push_strings(input int unsigned n);
		int unsigned chars;
		for (int s = 0; s < n; s++) begin
			chars = $urandom_range(1, 6);
			repeat (chars) append_byte(8'($urandom_range(1, 255)));
			append_byte(8'h00);
		end
		if (n == 0)
			append_byte(8'h00);
		append_byte(8'h00);
	endfunction

	// Append one structure with random header, size form, type code and strings.
	function automatic void push_random_structure();
		int unsigned r;
		logic [7:0]  kind;
		logic [7:0]  len;
		logic [15:0] word;
		logic [31:0] ext;
		logic [7:0]  code;
		logic [15:0] cspeed;
		kind = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
			smbmd_pkg::TYPE_MEMORY_DEVICE;
		r = $urandom_range(0, 99);
		if (r < 5)
			len = 8'($urandom_range(0, 3));
		else if (r < 12)
			len = 8'($urandom_range(4, 255));
		else if (r < 35)
			len = 8'($urandom_range(4, 8'h27));
		else
			len = 8'($urandom_range(8'h28, 8'h54));
		case ($urandom_range(0, 9))
			0:       word = smbmd_pkg::SIZE_NONE;
			1:       word = smbmd_pkg::SIZE_UNKNOWN;
			2, 3:    word = smbmd_pkg::SIZE_EXTENDED;
			4, 5:    word = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
			default: word = 16'($urandom_range(1, 16'h7FFE));
		endcase
		case ($urandom_range(0, 5))
			0:       ext = 32'h0;
			1:       ext = 32'h8000_0000;
			2:       ext = 32'hFFFF_FFFF;
			default: ext = $urandom;
		endcase
		case ($urandom_range(0, 6))
			0:       code = smbmd_pkg::MT_DDR;
			1:       code = smbmd_pkg::MT_DDR2;
			2:       code = smbmd_pkg::MT_DDR3;
			3:       code = smbmd_pkg::MT_DDR4;
			4:       code = smbmd_pkg::MT_DDR5;
			default: code = 8'($urandom_range(0, 255));
		endcase
		cspeed = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom_range(0, 16'hFFFF));
		push_memory_device(kind, len, word, ext, code, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)), cspeed,
			16'($urandom_range(0, 16'hFFFF)), 1'b1);
		push_strings($urandom_range(0, 3));
	endfunction

	// Offer one byte and wait for its transfer; entered and left at a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		table_byte <= b;
		table_end  <= last;
		do
			@(posedge clk);
		while (!in_ready);
		predict_table_byte(b, last);
		@(negedge clk);
	endtask

	// Stream the pending table with the end flag on its final byte.
	task automatic send_table();
		int unsigned last;
		last = table_bytes.size() - 1;
		for (int unsigned i = 0; i <= last; i++)
			send_byte(table_bytes[i], i == last);
		table_bytes.delete();
	endtask

	// Stop offering and wait until every expected record has been transferred.
	task automatic wait_for_records();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_records.size() != 0);
	endtask

	// A length byte below four halts parsing until the table ends.
	task automatic test_short_header();
		table_bytes = '{smbmd_pkg::TYPE_MEMORY_DEVICE, 8'h03, 8'hAA, 8'h00};
		send_table();
	endtask

	// A table that ends within the first four bytes of a structure gives nothing.
	task automatic test_early_table_end();
		table_bytes = '{smbmd_pkg::TYPE_MEMORY_DEVICE, 8'h20, 8'h55};
		send_table();
	endtask

	// KiB size form; a zero last byte of the formatted area must not start the double zero.
	task automatic test_kib_size_and_boundary_zero();
		push_memory_device(smbmd_pkg::TYPE_MEMORY_DEVICE, 8'h0F, 16'hFFFE, 32'h0, 8'h00,
			8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0);
		append_byte(8'h00);
		append_byte(8'h58);
		append_byte(8'h00);
		append_byte(8'h00);
		send_table();
	endtask

	// Table end inside the string set still emits the structure.
	task automatic test_cut_in_string_set();
		push_memory_device(smbmd_pkg::TYPE_MEMORY_DEVICE, 8'h0E, 16'h0001, 32'h0,
			smbmd_pkg::MT_DDR4, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		append_byte(8'h53);
		send_table();
	endtask

	// Extended size at its maximum, configured speed falling back, all fields present.
	task automatic test_full_record();
		push_memory_device(smbmd_pkg::TYPE_MEMORY_DEVICE, 8'h28, smbmd_pkg::SIZE_EXTENDED,
			32'hFFFF_FFFF, smbmd_pkg::MT_DDR5, 8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF,
			1'b1);
		push_strings(2);
		send_table();
	endtask

	// The receiver holds off while short records keep coming, so the input must stall.
	task automatic test_output_backpressure();
		sender_gaps = 1'b0;
		long_hold   = 1'b1;
		repeat (20) begin
			push_memory_device(smbmd_pkg::TYPE_MEMORY_DEVICE, 8'h0E,
				16'($urandom_range(1, 16'h7FFE)), 32'h0, 8'h00, 8'h00, 8'h00, 16'h0,
				16'h0, 16'h0, 1'b1);
			push_strings(0);
		end
		send_table();
		wait_for_records();
		while (long_hold)
			@(negedge clk);
		sender_gaps = 1'b1;
	endtask

	// Random tables: mostly well formed, some cut short, some pure noise.
	task automatic test_random_tables();
		int unsigned r;
		int unsigned keep;
		bit          paused;
		paused = 1'b0;
		while (bytes_parsed < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				repeat ($urandom_range(1, 20))
					append_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 5)) push_random_structure();
				if (r < 18) begin
					keep = $urandom_range(1, table_bytes.size());
					while (table_bytes.size() > keep)
						void'(table_bytes.pop_back());
				end
			end
			send_table();
			// Halfway through, let the block run dry once.
			if (!paused && bytes_parsed >= RANDOM_BYTES / 2) begin
				paused = 1'b1;
				wait_for_records();
			end
		end
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_steady_stream();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		repeat (2) begin
			repeat ($urandom_range(1, 4)) push_random_structure();
			send_table();
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare every transferred record with the oldest expected one.
	always @(posedge clk) begin : check_output
		smbmd_pkg::record_t got;
		smbmd_pkg::record_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{size_mib, max_speed_mts, configured_speed_mts, voltage_mv,
				memory_kind, locator_string, bank_string};
			if (expected_records.size() == 0) begin
				report_error($sformatf("unexpected record size %0d kind %0d loc %0d bank %0d",
					got.size_mib, got.memory_kind, got.locator_string, got.bank_string));
			end else begin
				want = expected_records.pop_front();
				compare_field("size_mib", 32'(want.size_mib), 32'(got.size_mib));
				compare_field("max_speed_mts", 32'(want.max_speed_mts),
					32'(got.max_speed_mts));
				compare_field("configured_speed_mts", 32'(want.configured_speed_mts),
					32'(got.configured_speed_mts));
				compare_field("voltage_mv", 32'(want.voltage_mv), 32'(got.voltage_mv));
				compare_field("memory_kind", 32'(want.memory_kind), 32'(got.memory_kind));
				compare_field("locator_string", 32'(want.locator_string),
					32'(got.locator_string));
				compare_field("bank_string", 32'(want.bank_string), 32'(got.bank_string));
			end
		end
	end

	// Run limit, well beyond the slowest correct run.
	initial begin : watchdog
		#(RUN_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Test sequence.
	initial begin : main
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_short_header();
		test_early_table_end();
		test_kib_size_and_boundary_zero();
		test_cut_in_string_set();
		test_full_record();
		test_output_backpressure();
		test_random_tables();
		test_steady_stream();
		wait_for_records();
		repeat (TAIL_CYCLES) @(negedge clk);
		while (expected_records.size() != 0) begin
			report_error($sformatf("record of size %0d never arrived",
				expected_records[0].size_mib));
			void'(expected_records.pop_front());
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
